// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// All of them check on the rising edge of the given clock and are
// switched off while the given reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MAD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define MAD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define MAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MAD_ASSERT(label, clk, rst, prop, msg)
`define MAD_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define MAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/core/mad_pkg.sv =====
package mad_pkg;

  localparam int WINDOW_DEFAULT      = 50;
  localparam int SAMPLE_BITS_DEFAULT = 12;

  // fixed field widths
  localparam int AVERAGE_BITS = 12;
  localparam int DECIM_BITS   = 6;

  localparam logic [DECIM_BITS-1:0] DECIM_RESET = 6'd10;

endpackage

// ===== rtl/core/mad_cell.sv =====
// One tap of the sample delay line.
module mad_cell #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  logic [SAMPLE_BITS-1:0] d,
  output logic [SAMPLE_BITS-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/core/mad_recip_div.sv =====
// Divide the window sum by WINDOW: reciprocal multiply, then shift.
// Two registered stages (product, result) with valid/stall flow.
module mad_recip_div #(
  parameter int WINDOW      = 50,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS+$clog2(WINDOW)-1:0] in_sum,
  output logic [mad_pkg::AVERAGE_BITS-1:0]   average,
  output logic                               average_valid,
  input  logic                               average_stall
);

  import mad_pkg::*;

`include "assert_macros.svh"

  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int SHIFT     = SUM_BITS + $clog2(WINDOW);
  localparam int PROD_BITS = 2 * SUM_BITS + 1;
  // ceil(2^SHIFT / WINDOW): exact floor for every sum below 2^SUM_BITS
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [SUM_BITS:0] RECIP = RECIP_FULL[SUM_BITS:0];

  logic                 prod_valid;
  logic [PROD_BITS-1:0] prod;
  logic [PROD_BITS-1:0] quot;
  logic                 out_advance;

  assign out_advance = !average_valid || !average_stall;
  assign in_ready    = !prod_valid || out_advance;
  assign quot        = prod >> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod <= PROD_BITS'(in_sum) * PROD_BITS'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_valid <= 1'b0;
    end else if (out_advance) begin
      average_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && prod_valid) begin
      average <= quot[AVERAGE_BITS-1:0];
    end
  end

  `MAD_ASSERT_SAME(a_ready_full, clk, rst, !in_ready, prod_valid && average_valid && average_stall, "divider refused a word with room to spare")
  `MAD_ASSERT_NEXT(a_prod_held, clk, rst, prod_valid && !in_ready, prod_valid && $stable(prod), "held product changed")
  `MAD_ASSERT_SAME(a_out_source, clk, rst, $rose(average_valid), $past(prod_valid), "result appeared without a product")

endmodule

// ===== rtl/core/moving_average_decimator.sv =====
// Channel   Dir  Handshake                     Payload
// sample    in   sample_valid / sample_stall   sample [SAMPLE_BITS]
// average   out  average_valid / average_stall average [12]
// config    in   cfg_write_en                  cfg_write_data [6] (decimation factor)
//
// One sample word per cycle while sample_stall is low; the delay-line shift and running-sum update
// complete in the cycle of acceptance.
// From the sample that completes an average, the sum passes through the hold register,
// the reciprocal-multiply product register and the result register to average_valid.
// Synchronous active-high reset clears the delay line, sum and counter and
// sets the decimation factor to 10.
// Stall on the output fills the two divider stages and the hold register, then
// stalls the input; up to three averages sit in flight.
module moving_average_decimator #(
  parameter int WINDOW      = mad_pkg::WINDOW_DEFAULT,
  parameter int SAMPLE_BITS = mad_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [SAMPLE_BITS-1:0]           sample,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  output logic [mad_pkg::AVERAGE_BITS-1:0] average,
  output logic                             average_valid,
  input  logic                             average_stall,
  input  logic                             cfg_write_en,
  input  logic [mad_pkg::DECIM_BITS-1:0]   cfg_write_data
);

  import mad_pkg::*;

`include "assert_macros.svh"

  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int CNT_BITS  = $clog2(WINDOW + 1);
  localparam int STEP_BITS = (CNT_BITS > DECIM_BITS) ? CNT_BITS : DECIM_BITS;

  // delay line: tap[0] newest, tap[WINDOW-1] oldest
  logic [SAMPLE_BITS-1:0] tap [WINDOW];

  logic [DECIM_BITS-1:0]  decim;
  logic [SUM_BITS-1:0]    sum;
  logic [SUM_BITS-1:0]    sum_next;
  logic [CNT_BITS-1:0]    count;
  logic [CNT_BITS-1:0]    count_inc;
  logic [CNT_BITS-1:0]    count_next;
  logic [STEP_BITS-1:0]   decim_ext;
  logic [STEP_BITS-1:0]   step;
  logic                   emit;
  logic                   accept;

  // sum word waiting for the divider
  logic                   hold_valid;
  logic [SUM_BITS-1:0]    hold_sum;
  logic                   div_ready;

  assign sample_stall = hold_valid && !div_ready;
  assign accept       = sample_valid && !sample_stall;

  // shift chain
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      mad_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .d     (sample),
        .q     (tap[i])
      );
    end else begin : g_body
      mad_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .d     (tap[i-1]),
        .q     (tap[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decim <= DECIM_RESET;
    end else if (cfg_write_en) begin
      decim <= cfg_write_data;
    end
  end

  // zero counts as one; anything above the window length saturates
  always_comb begin
    decim_ext = STEP_BITS'(decim);
    if (decim_ext == '0) begin
      step = STEP_BITS'(1);
    end else if (decim_ext > STEP_BITS'(WINDOW)) begin
      step = STEP_BITS'(WINDOW);
    end else begin
      step = decim_ext;
    end
  end

  always_comb begin
    sum_next  = sum + SUM_BITS'(sample) - SUM_BITS'(tap[WINDOW-1]);
    count_inc = count + CNT_BITS'(1);
    emit      = (count_inc >= CNT_BITS'(WINDOW));
    if (emit) begin
      count_next = count_inc - step[CNT_BITS-1:0];
    end else begin
      count_next = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (accept) begin
      sum   <= sum_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept && emit) begin
      hold_valid <= 1'b1;
    end else if (div_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      hold_sum <= sum_next;
    end
  end

  mad_recip_div #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (hold_valid),
    .in_ready      (div_ready),
    .in_sum        (hold_sum),
    .average       (average),
    .average_valid (average_valid),
    .average_stall (average_stall)
  );

  `MAD_ASSERT(a_count_range, clk, rst, count < CNT_BITS'(WINDOW), "sample counter left its range")
  `MAD_ASSERT_NEXT(a_emit_held, clk, rst, accept && emit, hold_valid && (hold_sum == sum), "average request lost")
  `MAD_ASSERT_SAME(a_stall_cause, clk, rst, sample_stall, hold_valid && average_valid, "input stalled with an empty pipe")
  `MAD_ASSERT_NEXT(a_sum_idle, clk, rst, !accept, $stable(sum) && $stable(count), "window state moved without a word")

endmodule

// ===== test/tb_moving_average_decimator.sv =====
module tb_moving_average_decimator;
  import mad_pkg::*;

  localparam int WIN           = WINDOW_DEFAULT;
  localparam int SBITS         = SAMPLE_BITS_DEFAULT;
  localparam int SUM_BITS      = 18;    // 50 * 4095 fits with room to spare
  localparam int ITEMS         = 1500;
  localparam int CALM_ITEMS    = 200;   // tail of the run with no idling at all
  localparam int SETTLE_CYCLES = 8;     // three-stage pipe plus margin
  localparam int SHOW_LIMIT    = 10;
  localparam logic [DECIM_BITS-1:0] FACTOR_TOP = '1;

  // Shapes of sample content used by the random phases.
  typedef enum int {
    MIX_UNIFORM,
    MIX_RAILS,
    MIX_ALL_MAX,
    MIX_ALL_ZERO,
    MIX_NEAR_MAX,
    MIX_NEAR_ZERO,
    MIX_COUNT
  } mix_t;

  logic                    clk            = 1'b0;
  logic                    rst            = 1'b1;
  logic [SBITS-1:0]        sample         = '0;
  logic                    sample_valid   = 1'b0;
  logic                    sample_stall;
  logic [AVERAGE_BITS-1:0] average;
  logic                    average_valid;
  logic                    average_stall  = 1'b0;
  logic                    cfg_write_en   = 1'b0;
  logic [DECIM_BITS-1:0]   cfg_write_data = '0;

  // Shadow copy of the block: delay line, running total, fill counter, factor.
  logic [SBITS-1:0]        delay_line [WIN];
  logic [SUM_BITS-1:0]     window_total;
  int unsigned             fill_count;
  logic [DECIM_BITS-1:0]   decim_factor;

  logic [AVERAGE_BITS-1:0] averages_due [$];
  int                      fault_count  = 0;
  int                      samples_sent = 0;
  bit                      calm         = 1'b0;

  moving_average_decimator #(
    .WINDOW      (WIN),
    .SAMPLE_BITS (SBITS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .sample         (sample),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .average        (average),
    .average_valid  (average_valid),
    .average_stall  (average_stall),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shift one accepted sample word into the shadow window; queue an average
  // whenever the fill counter reaches a full window.
  function automatic void absorb_sample(input logic [SBITS-1:0] s);
    logic [SBITS-1:0] oldest;
    int unsigned      stride;
    oldest = delay_line[0];
    for (int i = 1; i < WIN; i++) delay_line[i-1] = delay_line[i];
    delay_line[WIN-1] = s;
    window_total = window_total + SUM_BITS'(s) - SUM_BITS'(oldest);
    fill_count++;
    if (fill_count >= WIN) begin
      // zero behaves as one; anything past the window length saturates to it
      if (decim_factor == '0) stride = 1;
      else if (32'(decim_factor) > WIN) stride = WIN;
      else stride = 32'(decim_factor);
      fill_count -= stride;
      averages_due.push_back(AVERAGE_BITS'(32'(window_total) / WIN));
    end
  endfunction

  function automatic void check_average(input logic [AVERAGE_BITS-1:0] got);
    logic [AVERAGE_BITS-1:0] want;
    if (averages_due.size() == 0) begin
      fault_count++;
      if (fault_count <= SHOW_LIMIT) $display("unexpected average word: actual %0d", got);
    end else begin
      want = averages_due.pop_front();
      if (got !== want) begin
        fault_count++;
        if (fault_count <= SHOW_LIMIT)
          $display("average mismatch: expected %0d, actual %0d", want, got);
      end
    end
  endfunction

  // Everything is sampled at the rising edge, before the NBA updates of that
  // edge land. Prediction runs ahead of checking within the one process, so
  // ordering between processes never matters.
  always @(posedge clk) begin
    if (rst) begin
      foreach (delay_line[i]) delay_line[i] = '0;
      window_total = '0;
      fill_count   = 0;
      decim_factor = DECIM_RESET;
    end else begin
      if (cfg_write_en) decim_factor = cfg_write_data;
      if (sample_valid && !sample_stall) absorb_sample(sample);
      if (average_valid && !average_stall) check_average(average);
    end
  end

  // Output back-pressure: random bursts of stalls, dropped for the tail.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        average_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        average_stall <= 1'b0;
      end
    end
  end

  // Offer one sample word and hold it until accepted. Valid is only dropped
  // when a gap is inserted, so back-to-back words keep it high throughout.
  task automatic send_sample(input logic [SBITS-1:0] s);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    samples_sent++;
  endtask

  // Block goes quiet: no words offered, every average delivered, then a settling
  // wait before the next step.
  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (averages_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_factor(input logic [DECIM_BITS-1:0] f);
    settle();
    cfg_write_data <= f;
    cfg_write_en   <= 1'b1;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  function automatic logic [SBITS-1:0] pick_sample(input mix_t mix);
    case (mix)
      MIX_RAILS:     return $urandom_range(0, 1) ? '1 : '0;
      MIX_ALL_MAX:   return '1;
      MIX_ALL_ZERO:  return '0;
      MIX_NEAR_MAX:  return '1 - SBITS'($urandom_range(0, 15));
      MIX_NEAR_ZERO: return SBITS'($urandom_range(0, 15));
      default:       return SBITS'($urandom);
    endcase
  endfunction

  task automatic run_phase(input logic [DECIM_BITS-1:0] f, input int n, input mix_t mix);
    write_factor(f);
    repeat (n) begin
      if (samples_sent >= ITEMS - CALM_ITEMS) calm = 1'b1;
      send_sample(pick_sample(mix));
    end
  endtask

  // Rails, alternating patterns and walking ones under the reset factor.
  // Fewer than a window, so nothing comes out yet.
  task automatic test_sample_rails();
    send_sample('0);
    send_sample('1);
    send_sample('0);
    send_sample('1);
    send_sample(12'hAAA);
    send_sample(12'h555);
    for (int b = 0; b < SBITS; b++) send_sample(SBITS'(1) << b);
    send_sample(12'h7FF);
    send_sample(12'h800);
  endtask

  // Finish the first window and run on without touching the register, so the
  // reset factor of ten sets the spacing.
  task automatic test_reset_factor();
    repeat (60) send_sample(pick_sample(MIX_UNIFORM));
  endtask

  // Factor zero, one, the window length, just past it and the top code.
  // The all-max run at factor one drives the average to full scale.
  task automatic test_factor_limits();
    run_phase('0, 60, MIX_UNIFORM);
    run_phase(DECIM_BITS'(1), 60, MIX_ALL_MAX);
    run_phase(DECIM_BITS'(1), 60, MIX_ALL_ZERO);
    run_phase(DECIM_BITS'(WIN), 120, MIX_UNIFORM);
    run_phase(DECIM_BITS'(WIN + 1), 120, MIX_RAILS);
    run_phase(FACTOR_TOP, 120, MIX_NEAR_MAX);
  endtask

  // Phases of random length, each with its own factor and sample shape.
  // The factor changes mid-stream, so partly counted windows carry across.
  task automatic test_random_phases();
    logic [DECIM_BITS-1:0] f;
    mix_t                  mix;
    int                    pick;
    while (samples_sent < ITEMS) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0: f = '0;
        1: f = DECIM_BITS'(1);
        2: f = DECIM_BITS'(WIN);
        3: f = FACTOR_TOP;
        default: f = DECIM_BITS'($urandom_range(0, 63));
      endcase
      if ($urandom_range(0, 2) == 0) mix = mix_t'($urandom_range(0, MIX_COUNT - 1));
      else mix = MIX_UNIFORM;
      run_phase(f, $urandom_range(20, 150), mix);
    end
  endtask

  task automatic test_drain();
    calm = 1'b1;
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sample_rails();
    test_reset_factor();
    test_factor_limits();
    test_random_phases();
    test_drain();
    if (fault_count == 0 && averages_due.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mad_pkg.sv
rtl/core/mad_cell.sv
rtl/core/mad_recip_div.sv
rtl/core/moving_average_decimator.sv
test/tb_moving_average_decimator.sv
